// ===== rtl/abip_pkg.sv =====
// Shared types and constants for the auto-base integer parser.
// No dependencies; every other file uses this package.
`default_nettype none

package abip_pkg;

    // Queue between front and back
    localparam int DEFAULT_QUEUE_DEPTH = 4;

    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 6;
    localparam int VALUE_W = 64;

    // Digit value given to bytes that are not 0-9, a-z or A-Z
    localparam logic [DIGIT_W-1:0] DIGIT_NONE = 6'd36;

    // One byte after classification, as the back end sees it
    typedef struct packed {
        logic               last;
        logic               is_nul;
        logic               is_zero;    // '0'
        logic               is_b;       // lowercase 'b'
        logic               is_x;       // 'x' or 'X'
        logic               is_space;   // ' ' or 9..13
        logic               is_sign;    // '+' or '-'
        logic               is_minus;   // '-'
        logic [DIGIT_W-1:0] digit;      // 0..35, DIGIT_NONE otherwise
    } abip_class_t;

endpackage

`default_nettype wire

// ===== rtl/abip_if.sv =====
// Valid/ready channel interfaces: byte stream in, parsed result out.
// Depends on abip_pkg for field widths.
`default_nettype none

interface abip_char_if;
    logic                          valid;
    logic                          ready;
    logic [abip_pkg::CHAR_W-1:0]   char_code;
    logic                          last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface abip_result_if;
    logic                          valid;
    logic                          ready;
    logic [abip_pkg::VALUE_W-1:0]  value;
    logic                          out_of_range;
    logic                          digits_seen;

    modport source (output valid, output value, output out_of_range,
                    output digits_seen, input ready);
    modport sink   (input valid, input value, input out_of_range,
                    input digits_seen, output ready);
endinterface

`default_nettype wire

// ===== rtl/abip_front.sv =====
// Front end: takes byte beats and classifies each byte for the back end.
// Depends on abip_pkg and abip_char_if.
`default_nettype none

module abip_front (
    abip_char_if.sink            chars,
    output logic                 push_valid,
    input  logic                 push_ready,
    output abip_pkg::abip_class_t push_data
);
    import abip_pkg::*;

    logic [CHAR_W-1:0] c;

    assign c = chars.char_code;

    always_comb
    begin
        push_data.last     = chars.last;
        push_data.is_nul   = (c == 8'h00);
        push_data.is_zero  = (c == 8'h30);
        push_data.is_b     = (c == 8'h62);
        push_data.is_x     = (c == 8'h78) || (c == 8'h58);
        push_data.is_space = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
        push_data.is_sign  = (c == 8'h2b) || (c == 8'h2d);
        push_data.is_minus = (c == 8'h2d);
        if ((c >= 8'h30) && (c <= 8'h39))
        begin
            push_data.digit = DIGIT_W'(c - 8'h30);
        end
        else if ((c >= 8'h61) && (c <= 8'h7a))
        begin
            push_data.digit = DIGIT_W'(c - 8'h61 + 8'd10);
        end
        else if ((c >= 8'h41) && (c <= 8'h5a))
        begin
            push_data.digit = DIGIT_W'(c - 8'h41 + 8'd10);
        end
        else
        begin
            push_data.digit = DIGIT_NONE;
        end
    end

    assign push_valid  = chars.valid;
    assign chars.ready = push_ready;

endmodule

`default_nettype wire

// ===== rtl/abip_queue.sv =====
// Short FIFO of classified bytes between front and back end.
// Depends on abip_pkg.
`default_nettype none

module abip_queue #(
    parameter int DEPTH = abip_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  abip_pkg::abip_class_t push_data,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output abip_pkg::abip_class_t pop_data
);
    import abip_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    abip_class_t       entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/abip_back.sv =====
// Back end: prefix/sign state machine, digit accumulator, saturation and
// the result output register. Depends on abip_pkg and abip_result_if.
`default_nettype none

module abip_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_wdata,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  abip_pkg::abip_class_t pop_data,
    abip_result_if.source         results
);
    import abip_pkg::*;

    typedef enum logic [7:0] {
        PH_FIRST  = 8'b0000_0001,
        PH_ZERO1  = 8'b0000_0010,
        PH_LEAD   = 8'b0000_0100,
        PH_SIGN   = 8'b0000_1000,
        PH_ZERO   = 8'b0001_0000,
        PH_X      = 8'b0010_0000,
        PH_DIGITS = 8'b0100_0000,
        PH_DONE   = 8'b1000_0000
    } phase_t;

    typedef enum logic [1:0] {
        RC_AUTO = 2'd0,
        RC_BIN  = 2'd1,
        RC_OCT  = 2'd2,
        RC_HEX  = 2'd3
    } radix_t;

    typedef struct packed {
        logic [VALUE_W-1:0] mag;
        logic               neg;
        logic               ovf;
        logic               any;
    } final_t;

    localparam int ACC_W = VALUE_W + 5;

    function automatic logic [DIGIT_W-1:0] radix_limit(radix_t rc);
        case (rc)
            RC_BIN:  radix_limit = 6'd2;
            RC_OCT:  radix_limit = 6'd8;
            RC_HEX:  radix_limit = 6'd16;
            default: radix_limit = 6'd10;
        endcase
    endfunction

    phase_t             phase_reg, phase_next;
    radix_t             rc_reg, rc_next;
    logic               neg_reg, neg_next;
    logic [VALUE_W-1:0] mag_reg, mag_next;
    logic               ovf_reg, ovf_next;
    logic               any_reg, any_next;
    logic               signed_mode_reg;

    logic               take;
    radix_t             take_rc;
    logic               lead_path, start_path, zchar_path;
    logic [DIGIT_W-1:0] d;
    logic [ACC_W-1:0]   mag_ext, scaled, acc_sum;

    final_t             fin_reg;
    logic               fin_valid_reg;
    logic               fin_ready;
    logic               go;

    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_range_reg;
    logic               out_digits_reg;

    logic [VALUE_W-1:0] limit, negated, fin_value;
    logic               fin_sat;

    assign d = pop_data.digit;

    // Per-byte parse step
    always_comb
    begin
        phase_next = phase_reg;
        rc_next    = rc_reg;
        neg_next   = neg_reg;
        any_next   = any_reg;
        take       = 1'b0;
        take_rc    = rc_reg;
        lead_path  = 1'b0;
        start_path = 1'b0;
        zchar_path = 1'b0;

        if (pop_data.is_nul)
        begin
            phase_next = PH_DONE;
        end
        else
        begin
            case (phase_reg)
                PH_FIRST:
                begin
                    if (pop_data.is_zero)
                    begin
                        any_next   = 1'b1;
                        phase_next = PH_ZERO1;
                    end
                    else
                    begin
                        lead_path = 1'b1;
                    end
                end
                PH_ZERO1:
                begin
                    if (pop_data.is_b)
                    begin
                        any_next   = 1'b0;
                        rc_next    = RC_BIN;
                        phase_next = PH_LEAD;
                    end
                    else
                    begin
                        zchar_path = 1'b1;
                    end
                end
                PH_LEAD:   lead_path  = 1'b1;
                PH_SIGN:   start_path = 1'b1;
                PH_ZERO:   zchar_path = 1'b1;
                PH_X:
                begin
                    if (d < 6'd16)
                    begin
                        rc_next = RC_HEX;
                        take_rc = RC_HEX;
                        take    = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_DIGITS:
                begin
                    if (d < radix_limit(rc_reg))
                    begin
                        take = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                default: ;
            endcase
        end

        if (lead_path)
        begin
            if (pop_data.is_space)
            begin
                phase_next = PH_LEAD;
            end
            else if (pop_data.is_sign)
            begin
                neg_next   = pop_data.is_minus;
                phase_next = PH_SIGN;
            end
            else
            begin
                start_path = 1'b1;
            end
        end

        if (start_path)
        begin
            if (rc_reg == RC_BIN)
            begin
                if (d < 6'd2)
                begin
                    take = 1'b1;
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
            else if (pop_data.is_zero)
            begin
                any_next   = 1'b1;
                phase_next = PH_ZERO;
            end
            else if ((d >= 6'd1) && (d <= 6'd9))
            begin
                take = 1'b1;
            end
            else
            begin
                phase_next = PH_DONE;
            end
        end

        if (zchar_path)
        begin
            if (pop_data.is_x)
            begin
                phase_next = PH_X;
            end
            else if (d < 6'd8)
            begin
                rc_next = RC_OCT;
                take_rc = RC_OCT;
                take    = 1'b1;
            end
            else
            begin
                phase_next = PH_DONE;
            end
        end

        if (take)
        begin
            any_next   = 1'b1;
            phase_next = PH_DIGITS;
        end
    end

    // Shared shift-add: mag * radix + digit, carry-out above bit 63 = overflow
    assign mag_ext = ACC_W'(mag_reg);

    always_comb
    begin
        case (take_rc)
            RC_BIN:  scaled = mag_ext << 1;
            RC_OCT:  scaled = mag_ext << 3;
            RC_HEX:  scaled = mag_ext << 4;
            default: scaled = (mag_ext << 3) + (mag_ext << 1);
        endcase
        acc_sum  = scaled + ACC_W'(d);
        mag_next = mag_reg;
        ovf_next = ovf_reg;
        if (take)
        begin
            if (|acc_sum[ACC_W-1:VALUE_W])
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                mag_next = acc_sum[VALUE_W-1:0];
            end
        end
    end

    // Back end takes a byte whenever the final stage can take a result
    assign fin_ready = !out_valid_reg || results.ready;
    assign go        = pop_valid && (!fin_valid_reg || fin_ready);
    assign pop_ready = go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            rc_reg    <= RC_AUTO;
            neg_reg   <= 1'b0;
            mag_reg   <= '0;
            ovf_reg   <= 1'b0;
            any_reg   <= 1'b0;
        end
        else if (go)
        begin
            if (pop_data.last)
            begin
                phase_reg <= PH_FIRST;
                rc_reg    <= RC_AUTO;
                neg_reg   <= 1'b0;
                mag_reg   <= '0;
                ovf_reg   <= 1'b0;
                any_reg   <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                rc_reg    <= rc_next;
                neg_reg   <= neg_next;
                mag_reg   <= mag_next;
                ovf_reg   <= ovf_next;
                any_reg   <= any_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signed_mode_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            signed_mode_reg <= cfg_wdata;
        end
    end

    // Final stage: raw magnitude and flags of a finished string
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (go && pop_data.last)
        begin
            fin_valid_reg <= 1'b1;
        end
        else if (fin_ready)
        begin
            fin_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && pop_data.last)
        begin
            fin_reg.mag <= mag_next;
            fin_reg.neg <= neg_next;
            fin_reg.ovf <= ovf_next;
            fin_reg.any <= any_next;
        end
    end

    // Saturation and sign
    always_comb
    begin
        limit   = fin_reg.neg ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
        negated = '0 - fin_reg.mag;
        if (signed_mode_reg)
        begin
            fin_sat   = fin_reg.ovf || (fin_reg.mag > limit);
            fin_value = fin_sat ? limit : (fin_reg.neg ? negated : fin_reg.mag);
        end
        else
        begin
            fin_sat   = fin_reg.ovf;
            fin_value = fin_sat ? {VALUE_W{1'b1}} : (fin_reg.neg ? negated : fin_reg.mag);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fin_valid_reg && fin_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_valid_reg && fin_ready)
        begin
            out_value_reg  <= fin_value;
            out_range_reg  <= fin_sat;
            out_digits_reg <= fin_reg.any;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.value        = out_value_reg;
    assign results.out_of_range = out_range_reg;
    assign results.digits_seen  = out_digits_reg;

endmodule

`default_nettype wire

// ===== rtl/auto_base_integer_parser_unit.sv =====
// Top level of the auto-base integer parser: front, queue and back end.
// Depends on abip_pkg, abip_if, abip_front, abip_queue and abip_back.
//
// Usage:
//   chars   - byte stream, one character per beat; last marks the final
//             byte of a string. A NUL or the first invalid byte ends the
//             parse, later bytes up to last are consumed and ignored.
//   results - one beat per string: value (64 bits, two's complement when
//             signed), out_of_range (saturated) and digits_seen.
//   cfg_we/cfg_wdata - signed_mode register, 1 = signed (reset value).
//             Write only while no string is in flight.
// Throughput: one byte per cycle while the output is not stalled. Each byte costs one pass
//   through the back end's shift-add accumulator (mag * radix + digit).
// Path: the last byte passes through the queue, the back end's final stage
//   and, via the saturation logic, the output register before results.valid rises.
// Stall: when results.ready is low the output register holds; one more
//   result waits in the final stage, then the back end stops draining the
//   queue, and chars.ready drops once the queue (QUEUE_DEPTH beats) fills.
// Reset: empties the queue and pipeline, clears the parse state to the
//   first character position and sets signed_mode.
`default_nettype none

module auto_base_integer_parser_unit #(
    parameter int QUEUE_DEPTH = abip_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_wdata,
    abip_char_if.sink     chars,
    abip_result_if.source results
);
    import abip_pkg::*;

    // front -> queue
    logic        push_valid;
    logic        push_ready;
    abip_class_t push_data;

    // queue -> back end
    logic        pop_valid;
    logic        pop_ready;
    abip_class_t pop_data;

    abip_front u_front (
        .chars      (chars),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    abip_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    abip_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .results   (results)
    );

endmodule

`default_nettype wire

// ===== tb/tb_auto_base_integer_parser_unit.sv =====
// Self-checking testbench for auto_base_integer_parser_unit: streams text strings,
// predicts each parsed result in a local model and compares every result beat.
// Depends on abip_pkg, abip_if and the parser RTL; needs no other file.

module tb_auto_base_integer_parser_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import abip_pkg::*;

    // ------------------------------------------------------------------
    // Run constants
    // ------------------------------------------------------------------
    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 10;
    localparam int IDLE_PCT       = 28;    // chance per cycle that a side idles
    localparam int PHASE_BYTES    = 230;   // random bytes per configuration phase
    localparam int NUM_PHASES     = 5;
    localparam int NO_IDLE_PHASE  = 2;     // both sides run flat out here
    localparam int HOLD_PHASE     = 3;     // receiver holds off here
    localparam int HOLD_CYCLES    = 120;   // long enough to fill queue and pipe
    localparam int SETTLE_CYCLES  = 8;     // margin for the back end registers plus the queue
    // Longest gap with no beat at all: the hold above, the settle pause plus a
    // run of random idles. Several times that still stays far below this.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_PRINTED    = 20;

    // ASCII bytes the parser reacts to
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_X = 8'h58;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_B = 8'h62;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] POS_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_MAG  = 64'h8000_0000_0000_0000;

    // Where the scanner stands within the current string
    typedef enum logic [2:0] {
        SCAN_FIRST,     // nothing consumed yet
        SCAN_ZERO1,     // first byte was '0', a 'b' may follow
        SCAN_SPACE,     // in leading whitespace (or right after "0b")
        SCAN_SIGNED,    // sign taken
        SCAN_ZERO,      // leading zero after whitespace/sign
        SCAN_HEXPFX,    // "0x" seen, needs a hex digit
        SCAN_DIGITS,    // accumulating digits
        SCAN_STOP       // parse ended, ignore until last
    } scan_phase_t;

    typedef enum logic [1:0] {
        RADIX_AUTO,     // decimal once digits start
        RADIX_BIN,
        RADIX_OCT,
        RADIX_HEX
    } radix_t;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } char_beat_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               out_of_range;
        logic               digits_seen;
    } parse_result_t;

    // ------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    always #(CLK_HALF) clk = ~clk;

    abip_char_if   chars_if ();
    abip_result_if res_if ();

    auto_base_integer_parser_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .chars     (chars_if),
        .results   (res_if)
    );

    // ------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------
    char_beat_t    pend_q[$];       // bytes waiting to be offered
    parse_result_t exp_q[$];        // predicted results, oldest first
    logic [7:0]    text_buf[$];     // string under construction

    bit          no_idle;
    int unsigned hold_requests;
    int unsigned holds_done;
    int unsigned hold_cnt;
    bit          char_taken;        // byte on the bus was taken at last edge

    int unsigned bytes_queued;
    int unsigned strings_queued;
    int unsigned results_checked;
    int unsigned saturated_seen;
    int unsigned mismatch_count;
    int unsigned quiet_cycles;
    int unsigned mode_writes;

    // Numbers around the 63- and 64-bit limits in decimal, hex and octal
    string limit_text [12] = '{
        "9223372036854775807", "9223372036854775808", "9223372036854775809",
        "18446744073709551615", "18446744073709551616", "99999999999999999999",
        "0x7fffffffffffffff", "0x8000000000000000", "0xFFFFFFFFFFFFFFFF",
        "0x10000000000000000", "01777777777777777777777", "02000000000000000000000"
    };

    // ------------------------------------------------------------------
    // Parser model: own copy of config and scan state
    // ------------------------------------------------------------------
    logic               model_signed;
    scan_phase_t        scan_phase;
    radix_t             scan_radix;
    logic               neg_seen;
    logic [VALUE_W-1:0] mag_acc;
    logic               mag_ovf;
    logic               digit_seen;

    function automatic void clear_scan();
        scan_phase = SCAN_FIRST;
        scan_radix = RADIX_AUTO;
        neg_seen   = 1'b0;
        mag_acc    = '0;
        mag_ovf    = 1'b0;
        digit_seen = 1'b0;
    endfunction

    function automatic logic [DIGIT_W-1:0] char_digit(logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return DIGIT_W'(c - CH_ZERO);
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
            return DIGIT_W'(c - CH_LOWER_A + 8'd10);
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
            return DIGIT_W'(c - CH_UPPER_A + 8'd10);
        return DIGIT_NONE;
    endfunction

    function automatic logic [63:0] radix_base();
        case (scan_radix)
            RADIX_BIN: return 64'd2;
            RADIX_OCT: return 64'd8;
            RADIX_HEX: return 64'd16;
            default:   return 64'd10;
        endcase
    endfunction

    // mag = mag * radix + d, or mark overflow and keep the old magnitude
    function automatic void take_digit(logic [DIGIT_W-1:0] d);
        logic [63:0] r;
        logic [63:0] d64;
        r   = radix_base();
        d64 = {{(64-DIGIT_W){1'b0}}, d};
        if (mag_acc > (ALL_ONES - d64) / r)
            mag_ovf = 1'b1;
        else
            mag_acc = mag_acc * r + d64;
        digit_seen = 1'b1;
        scan_phase = SCAN_DIGITS;
    endfunction

    function automatic void digit_start(logic [7:0] c);
        logic [DIGIT_W-1:0] d;
        d = char_digit(c);
        if (scan_radix == RADIX_BIN)
        begin
            if (d < 2)
                take_digit(d);
            else
                scan_phase = SCAN_STOP;
        end
        else if (c == CH_ZERO)
        begin
            digit_seen = 1'b1;
            scan_phase = SCAN_ZERO;
        end
        else if (c > CH_ZERO && c <= CH_NINE)
            take_digit(d);
        else
            scan_phase = SCAN_STOP;
    endfunction

    function automatic void lead_char(logic [7:0] c);
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
            scan_phase = SCAN_SPACE;
        else if (c == CH_PLUS || c == CH_MINUS)
        begin
            neg_seen   = (c == CH_MINUS);
            scan_phase = SCAN_SIGNED;
        end
        else
            digit_start(c);
    endfunction

    function automatic void zero_char(logic [7:0] c);
        logic [DIGIT_W-1:0] d;
        d = char_digit(c);
        if (c == CH_LOWER_X || c == CH_UPPER_X)
            scan_phase = SCAN_HEXPFX;
        else if (d < 8)
        begin
            scan_radix = RADIX_OCT;
            take_digit(d);
        end
        else
            scan_phase = SCAN_STOP;
    endfunction

    function automatic void scan_byte(logic [7:0] c);
        logic [DIGIT_W-1:0] d;
        d = char_digit(c);
        if (c == CH_NUL)
            scan_phase = SCAN_STOP;
        else
        begin
            case (scan_phase)
                SCAN_FIRST:
                    if (c == CH_ZERO)
                    begin
                        digit_seen = 1'b1;
                        scan_phase = SCAN_ZERO1;
                    end
                    else
                        lead_char(c);
                SCAN_ZERO1:
                    // "0b" only counts at the very start; the '0' is no digit then
                    if (c == CH_LOWER_B)
                    begin
                        digit_seen = 1'b0;
                        scan_radix = RADIX_BIN;
                        scan_phase = SCAN_SPACE;
                    end
                    else
                        zero_char(c);
                SCAN_SPACE:  lead_char(c);
                SCAN_SIGNED: digit_start(c);
                SCAN_ZERO:   zero_char(c);
                SCAN_HEXPFX:
                    if (d < 16)
                    begin
                        scan_radix = RADIX_HEX;
                        take_digit(d);
                    end
                    else
                        scan_phase = SCAN_STOP;
                SCAN_DIGITS:
                    if ({{(64-DIGIT_W){1'b0}}, d} < radix_base())
                        take_digit(d);
                    else
                        scan_phase = SCAN_STOP;
                default: ;
            endcase
        end
    endfunction

    // Final value of the string, with saturation, then start over
    function automatic parse_result_t close_string();
        parse_result_t res;
        logic [63:0]   lim;
        res.out_of_range = mag_ovf;
        res.digits_seen  = digit_seen;
        if (model_signed)
        begin
            lim = neg_seen ? NEG_MAG : POS_MAX;
            if (mag_ovf || mag_acc > lim)
            begin
                res.out_of_range = 1'b1;
                res.value        = lim;
            end
            else
                res.value = neg_seen ? 64'd0 - mag_acc : mag_acc;
        end
        else if (mag_ovf)
            res.value = ALL_ONES;
        else
            res.value = neg_seen ? 64'd0 - mag_acc : mag_acc;
        clear_scan();
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("[%0t] MISMATCH %s: got 0x%016h want 0x%016h (after %0d results)",
                     $realtime, what, got, want, results_checked);
    endtask

    // ------------------------------------------------------------------
    // Driver: offers pending bytes at the falling edge, holds an offered
    // beat until the rising edge that takes it.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            chars_if.valid <= 1'b0;
        else if (chars_if.valid && !char_taken)
            ;   // beat still on the bus, keep it
        else if (pend_q.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT))
        begin
            chars_if.valid     <= 1'b1;
            chars_if.char_code <= pend_q[0].code;
            chars_if.last      <= pend_q[0].last;
            void'(pend_q.pop_front());
        end
        else
            chars_if.valid <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, plus long hold-offs on request.
    // The hold length is counted here so the sender keeps going meanwhile.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            res_if.ready <= 1'b0;
        else if (hold_cnt != 0)
        begin
            hold_cnt--;
            res_if.ready <= 1'b0;
        end
        else if (holds_done < hold_requests)
        begin
            holds_done++;
            hold_cnt = HOLD_CYCLES - 1;
            res_if.ready <= 1'b0;
        end
        else
            res_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // Monitor: samples both channels at the rising edge, checks result
    // beats against the oldest prediction, then feeds the accepted byte
    // to the model. Also runs the watchdog.
    // ------------------------------------------------------------------
    parse_result_t want_res;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            char_taken   <= 1'b0;
            model_signed = 1'b1;
            clear_scan();
            quiet_cycles = 0;
        end
        else
        begin
            char_taken <= chars_if.valid && chars_if.ready;

            if (cfg_we)
                model_signed = cfg_wdata;

            // A result can never stem from the byte taken at this same edge,
            // so check first and predict after.
            if (res_if.valid && res_if.ready)
            begin
                if (exp_q.size() == 0)
                    report_mismatch("unexpected result value", res_if.value, 64'd0);
                else
                begin
                    want_res = exp_q.pop_front();
                    if (res_if.value !== want_res.value)
                        report_mismatch("value", res_if.value, want_res.value);
                    if (res_if.out_of_range !== want_res.out_of_range)
                        report_mismatch("out_of_range", 64'(res_if.out_of_range),
                                        64'(want_res.out_of_range));
                    if (res_if.digits_seen !== want_res.digits_seen)
                        report_mismatch("digits_seen", 64'(res_if.digits_seen),
                                        64'(want_res.digits_seen));
                    if (want_res.out_of_range)
                        saturated_seen++;
                    results_checked++;
                end
            end

            if (chars_if.valid && chars_if.ready)
            begin
                scan_byte(chars_if.char_code);
                if (chars_if.last)
                    exp_q.push_back(close_string());
            end

            if ((chars_if.valid && chars_if.ready) || (res_if.valid && res_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] watchdog: no beat for %0d cycles, %0d pending, %0d due",
                         $realtime, quiet_cycles, pend_q.size(), exp_q.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Moves the staged string to the driver queue, last on the final byte
    task automatic commit_text();
        for (int i = 0; i < text_buf.size(); i++)
            pend_q.push_back('{code: text_buf[i], last: (i == text_buf.size() - 1)});
        bytes_queued += text_buf.size();
        strings_queued++;
        text_buf.delete();
    endtask

    task automatic append_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    function automatic logic [7:0] digit_char(int unsigned v);
        if (v < 10)
            return CH_ZERO + 8'(v);
        return ($urandom_range(1) ? CH_LOWER_A : CH_UPPER_A) + 8'(v - 10);
    endfunction

    function automatic logic [7:0] space_char();
        return $urandom_range(1) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR));
    endfunction

    function automatic logic [7:0] sign_char();
        return $urandom_range(1) ? CH_MINUS : CH_PLUS;
    endfunction

    // One random string. Mostly well-formed numbers in each radix, some
    // right at the saturation limits, the rest noise and trailing junk.
    task automatic add_random_string();
        int unsigned kind;
        int unsigned len;
        kind = $urandom_range(99);
        if ($urandom_range(99) < 20)
            repeat ($urandom_range(1, 2)) text_buf.push_back(space_char());
        if ($urandom_range(99) < 30)
            text_buf.push_back(sign_char());

        if (kind < 25)
        begin
            // decimal, mostly short, sometimes past 64 bits
            len = ($urandom_range(3) == 0) ? $urandom_range(15, 22) : $urandom_range(1, 6);
            text_buf.push_back(digit_char($urandom_range(1, 9)));
            repeat (len - 1) text_buf.push_back(digit_char($urandom_range(9)));
        end
        else if (kind < 40)
        begin
            // hex; zero digits leaves a dangling prefix
            text_buf.push_back(CH_ZERO);
            text_buf.push_back($urandom_range(1) ? CH_LOWER_X : CH_UPPER_X);
            len = ($urandom_range(3) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 6);
            repeat (len) text_buf.push_back(digit_char($urandom_range(15)));
        end
        else if (kind < 52)
        begin
            text_buf.push_back(CH_ZERO);
            len = ($urandom_range(3) == 0) ? $urandom_range(20, 23) : $urandom_range(0, 6);
            repeat (len) text_buf.push_back(digit_char($urandom_range(7)));
        end
        else if (kind < 66)
        begin
            // binary prefix, optionally whitespace/sign or a repeated prefix after it
            text_buf.push_back(CH_ZERO);
            text_buf.push_back(CH_LOWER_B);
            if ($urandom_range(99) < 15)
                text_buf.push_back($urandom_range(1) ? space_char() : sign_char());
            if ($urandom_range(99) < 10)
            begin
                text_buf.push_back(CH_ZERO);
                text_buf.push_back(CH_LOWER_B);
            end
            len = ($urandom_range(4) == 0) ? $urandom_range(60, 66) : $urandom_range(0, 10);
            repeat (len) text_buf.push_back(digit_char($urandom_range(1)));
        end
        else if (kind < 78)
            append_str(limit_text[$urandom_range(11)]);
        else
            repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(255)));

        if ($urandom_range(99) < 25)
            repeat ($urandom_range(1, 3)) text_buf.push_back(8'($urandom_range(255)));
        commit_text();
    endtask

    // Sender pause: nothing pending, nothing on the bus, every result in,
    // then the SETTLE_CYCLES pause before the register may change.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pend_q.size() != 0 || chars_if.valid || exp_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_signed_mode(input logic mode);
        @(negedge clk);
        cfg_wdata <= mode;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        mode_writes++;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned target;

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = 1'b0;
        chars_if.valid     = 1'b0;
        chars_if.char_code = '0;
        chars_if.last      = 1'b0;
        res_if.ready       = 1'b0;
        no_idle            = 1'b0;
        hold_requests      = 0;
        holds_done         = 0;
        hold_cnt           = 0;
        bytes_queued       = 0;
        strings_queued     = 0;
        results_checked    = 0;
        saturated_seen     = 0;
        mismatch_count     = 0;
        mode_writes        = 0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Directed strings under the reset setting (signed)
        append_str("0b101");  commit_text();    // binary prefix
        append_str("0x");     commit_text();    // dangling hex prefix
        append_str("0b0b1");  commit_text();    // second binary prefix stops
        append_str("0b");     commit_text();    // prefix with no digit
        text_buf.push_back(8'hFF); commit_text();   // byte above 127
        append_str("-17");    commit_text();
        append_str("07");     commit_text();    // octal
        append_str("0Xf");    commit_text();
        text_buf.push_back(CH_NUL);             // NUL ends parse, '5' ignored
        text_buf.push_back(CH_ZERO + 8'd5);
        commit_text();
        wait_drained();

        // Random phases, alternating unsigned and signed
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_signed_mode((ph % 2) ? 1'b1 : 1'b0);
            no_idle = (ph == NO_IDLE_PHASE);
            target  = bytes_queued + PHASE_BYTES;
            while (bytes_queued < target)
                add_random_string();
            // Receiver stalls long while the sender keeps offering
            if (ph == HOLD_PHASE)
                hold_requests++;
            wait_drained();
        end

        if (exp_q.size() != 0)
            report_mismatch("results never seen", 64'(exp_q.size()), 64'd0);

        $display("Summary: %0d strings in %0d byte beats, %0d results checked (%0d saturated)",
                 strings_queued, bytes_queued, results_checked, saturated_seen);
        $display("Summary: %0d signed_mode writes, %0d mismatches", mode_writes, mismatch_count);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
